// ===== rtl/xtea_pkg.sv =====
// ============================================================================
// xtea_pkg
// Shared constants and round helpers for the XTEA block cipher pipeline.
// ============================================================================
package xtea_pkg;

    localparam int          WORD_W    = 32;
    localparam int          KEY_WORDS = 4;
    localparam int          KEY_IDX_W = 2;
    localparam logic [31:0] DELTA     = 32'h9E3779B9;

    // Key register indexes on the config port
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_ZERO  = 2'd0;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_ONE   = 2'd1;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_TWO   = 2'd2;
    localparam logic [KEY_IDX_W-1:0] KEY_IDX_THREE = 2'd3;

    typedef logic [WORD_W-1:0] word_t;

    // Direction codes
    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    // delta * n mod 2^32, elaboration time only
    function automatic word_t sum_at(input int n);
        logic [63:0] prod;
        prod = 64'(DELTA) * 64'(n);
        return prod[WORD_W-1:0];
    endfunction

    // Feistel mixing term of one half-round
    function automatic word_t mix_word(input word_t v, input word_t sum, input word_t k);
        return (((v << 4) ^ (v >> 5)) + v) ^ (sum + k);
    endfunction

endpackage

// ===== rtl/xtea_block_cipher.sv =====
// ============================================================================
// xtea_block_cipher
// Fully pipelined XTEA encrypt/decrypt, one half-round per register stage.
// ============================================================================
//
//  Channel   Ports                                     Handshake
//  --------  ----------------------------------------  --------------------------
//  request   start, req_type, left_word, right_word     taken when start && !busy
//  result    done, out_left_word, out_right_word         one-cycle strobe on done
//  config    cfg_we, cfg_index, cfg_wdata                written when cfg_we
//
//  Each of the 2*ROUNDS register stages runs one Feistel half-round
//  (shift/xor, add, xor, add). A request can enter every cycle; busy stays low.
//  Reset clears the stage valid bits and the four key words.
//  The receiver cannot stall: results leave the last stage as they arrive.
//  Key words are read live by every stage, so write them only while idle.
//
module xtea_block_cipher #(
    parameter int ROUNDS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // request
    input  logic                           start,
    output logic                           busy,
    input  logic                           req_type,
    input  logic [31:0]                    left_word,
    input  logic [31:0]                    right_word,

    // result
    output logic                           done,
    output logic [31:0]                    out_left_word,
    output logic [31:0]                    out_right_word,

    // config
    input  logic                           cfg_we,
    input  logic [xtea_pkg::KEY_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_wdata
);

    localparam int STAGES = 2 * ROUNDS;

    // ------------------------------------------------------------------------
    // Key words
    // ------------------------------------------------------------------------
    xtea_pkg::word_t key_reg [xtea_pkg::KEY_WORDS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < xtea_pkg::KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                xtea_pkg::KEY_IDX_ZERO:  key_reg[0] <= cfg_wdata;
                xtea_pkg::KEY_IDX_ONE:   key_reg[1] <= cfg_wdata;
                xtea_pkg::KEY_IDX_TWO:   key_reg[2] <= cfg_wdata;
                xtea_pkg::KEY_IDX_THREE: key_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stage registers: stage s holds the block after half-round s
    // ------------------------------------------------------------------------
    xtea_pkg::word_t v0_reg  [STAGES];
    xtea_pkg::word_t v1_reg  [STAGES];
    logic            dir_reg [STAGES];
    logic            vld_reg [STAGES];

    // Pipeline never backs up
    assign busy = 1'b0;

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        localparam int RND  = s / 2;
        localparam int HALF = s % 2;

        // Encrypt: first half uses sum before the step, second half after it.
        // Decrypt walks the same sums backward, starting at delta*ROUNDS.
        localparam logic [31:0] ENC_SUM =
            xtea_pkg::sum_at((HALF == 1) ? RND + 1 : RND);
        localparam logic [31:0] DEC_SUM =
            xtea_pkg::sum_at((HALF == 1) ? ROUNDS - RND - 1 : ROUNDS - RND);
        // v0 updates pick key by sum[1:0], v1 updates by sum[12:11]
        localparam logic [1:0] ENC_KEY = (HALF == 1) ? ENC_SUM[12:11] : ENC_SUM[1:0];
        localparam logic [1:0] DEC_KEY = (HALF == 1) ? DEC_SUM[1:0]   : DEC_SUM[12:11];

        xtea_pkg::word_t src_v0;
        xtea_pkg::word_t src_v1;
        logic            src_dir;
        logic            src_vld;

        if (s == 0)
        begin : g_first
            assign src_v0  = left_word;
            assign src_v1  = right_word;
            assign src_dir = req_type;
            assign src_vld = start;
        end
        else
        begin : g_rest
            assign src_v0  = v0_reg[s-1];
            assign src_v1  = v1_reg[s-1];
            assign src_dir = dir_reg[s-1];
            assign src_vld = vld_reg[s-1];
        end

        logic            upd_lo;     // this half-round rewrites v0
        xtea_pkg::word_t mix_in;
        xtea_pkg::word_t target;
        xtea_pkg::word_t round_key;
        xtea_pkg::word_t round_sum;
        xtea_pkg::word_t mix_val;
        xtea_pkg::word_t result;
        xtea_pkg::word_t v0_next;
        xtea_pkg::word_t v1_next;

        always_comb
        begin
            upd_lo    = (HALF == 0) ^ (src_dir == xtea_pkg::DIR_DECRYPT);
            mix_in    = upd_lo ? src_v1 : src_v0;
            target    = upd_lo ? src_v0 : src_v1;
            round_key = (src_dir == xtea_pkg::DIR_DECRYPT) ? key_reg[DEC_KEY]
                                                            : key_reg[ENC_KEY];
            round_sum = (src_dir == xtea_pkg::DIR_DECRYPT) ? DEC_SUM : ENC_SUM;
            mix_val   = xtea_pkg::mix_word(mix_in, round_sum, round_key);
            result    = (src_dir == xtea_pkg::DIR_DECRYPT) ? target - mix_val
                                                            : target + mix_val;
            v0_next   = upd_lo ? result : src_v0;
            v1_next   = upd_lo ? src_v1 : result;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= src_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            v0_reg[s]  <= v0_next;
            v1_reg[s]  <= v1_next;
            dir_reg[s] <= src_dir;
        end
    end

    // ------------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------------
    assign done           = vld_reg[STAGES-1];
    assign out_left_word  = v0_reg[STAGES-1];
    assign out_right_word = v1_reg[STAGES-1];

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // Every accepted request comes out after exactly the pipeline latency
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(STAGES) done)
        else $error("accepted request did not produce a result on time");

    // No result appears without a request that latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##(STAGES) !done)
        else $error("result strobe without a matching request");

    // Direction tag stays aligned with the valid bit through the pipe
    a_dir_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(STAGES) (dir_reg[STAGES-1] == $past(req_type, STAGES)))
        else $error("direction tag lost alignment with its block");

endmodule
